[src/apu_pkg.sv]
// shared types and constants for the alpha premultiply unit
// item structs for both channels, the divider cell payload and register codes
// no dependencies
package apu_pkg;

  localparam int NCOL    = 3;   // colour bands: red, green, blue
  localparam int CW      = 32;  // component width
  localparam int FLOOR_W = 17;
  localparam int QW      = 49;  // numerator / quotient width, one divider cell per bit
  localparam int DW      = 33;  // divisor width (twice |alpha|)
  localparam int RW      = 33;  // partial remainder width
  localparam int PW      = 2 * CW;
  localparam int AW      = 3;   // apb address width

  localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(1);

  typedef enum logic {
    FUNC_PREMUL   = 1'b0,
    FUNC_UNPREMUL = 1'b1
  } func_t;

  // word index of the alpha floor register
  localparam logic REG_ALPHA_FLOOR = 1'b0;

  localparam logic [CW-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [CW-1:0] NEG_MAX = 32'h8000_0000;

  typedef struct packed {
    logic            func;
    logic [CW-1:0]   red_in;
    logic [CW-1:0]   green_in;
    logic [CW-1:0]   blue_in;
    logic [CW-1:0]   alpha_in;
    logic            last_in;
  } in_item_t;

  typedef struct packed {
    logic [CW-1:0]   red_out;
    logic [CW-1:0]   green_out;
    logic [CW-1:0]   blue_out;
    logic [CW-1:0]   alpha_out;
    logic            saturated;
    logic            last_out;
  } out_item_t;

  // what one divider cell hands to the next
  typedef struct packed {
    logic                       divide;    // unpremultiply item, cells step it
    logic                       zero;      // unpremultiply by zero alpha
    logic                       last;
    logic [CW-1:0]              alpha_out;
    logic [NCOL-1:0]            neg;
    logic [DW-1:0]              d;
    logic [NCOL-1:0][QW-1:0]    nq;        // numerator bits out on top, quotient in below
    logic [NCOL-1:0][RW-1:0]    rem;
  } cell_t;

endpackage

[src/apu_front.sv]
// front end: sign/magnitude split, alpha floor, 32x32 products, divider load
// three registered stages ahead of the divider chain
// depends on apu_pkg
module apu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  apu_pkg::in_item_t in_data,
  input  logic [16:0]       floor_val,
  output logic              cell_valid,
  output apu_pkg::cell_t    cell_data
);
  import apu_pkg::*;

  logic [CW-1:0] col [NCOL];

  // stage 0
  logic                  v0_r;
  logic                  div0_r, zero0_r, last0_r;
  logic [CW-1:0]         aout0_r, ma0_r;
  logic [NCOL-1:0]       neg0_r;
  logic [CW-1:0]         cmag0_r [NCOL];

  // stage 1
  logic                  v1_r;
  logic                  div1_r, zero1_r, last1_r;
  logic [CW-1:0]         aout1_r, ma1_r;
  logic [NCOL-1:0]       neg1_r;
  logic [CW-1:0]         cmag1_r [NCOL];
  logic [PW-1:0]         prod1_r [NCOL];

  // stage 2
  logic                  v2_r;
  cell_t                 c2_r;

  logic                  unpre;
  logic [CW-1:0]         alpha, floor_ext, a_used, amag;
  logic                  a_lt;
  cell_t                 c2_nxt;
  logic [PW-1:0]         rnd [NCOL];

  always_comb begin
    col[0] = in_data.red_in;
    col[1] = in_data.green_in;
    col[2] = in_data.blue_in;
  end

  assign unpre     = (in_data.func == FUNC_UNPREMUL);
  assign alpha     = in_data.alpha_in;
  assign floor_ext = {{(CW-FLOOR_W){1'b0}}, floor_val};
  assign a_lt      = $signed(alpha) < $signed(floor_ext);
  assign a_used    = a_lt ? floor_ext : alpha;
  assign amag      = alpha[CW-1] ? (~alpha + CW'(1)) : alpha;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div0_r  <= unpre;
      zero0_r <= unpre && (alpha == '0);
      last0_r <= in_data.last_in;
      ma0_r   <= unpre ? amag : a_used;
      if (unpre) begin
        aout0_r <= (alpha == floor_ext) ? '0 : alpha;
      end else begin
        aout0_r <= a_used;
      end
      for (int b = 0; b < NCOL; b++) begin
        cmag0_r[b] <= col[b][CW-1] ? (~col[b] + CW'(1)) : col[b];
        neg0_r[b]  <= col[b][CW-1] ^ (unpre & alpha[CW-1]);
      end

      div1_r  <= div0_r;
      zero1_r <= zero0_r;
      last1_r <= last0_r;
      ma1_r   <= ma0_r;
      aout1_r <= aout0_r;
      neg1_r  <= neg0_r;
      for (int b = 0; b < NCOL; b++) begin
        cmag1_r[b] <= cmag0_r[b];
        prod1_r[b] <= PW'(cmag0_r[b]) * PW'(ma0_r);
      end

      c2_r <= c2_nxt;
    end
  end

  always_comb begin
    c2_nxt.divide    = div1_r;
    c2_nxt.zero      = zero1_r;
    c2_nxt.last      = last1_r;
    c2_nxt.alpha_out = aout1_r;
    c2_nxt.neg       = neg1_r;
    c2_nxt.d         = {ma1_r, 1'b0};
    for (int b = 0; b < NCOL; b++) begin
      rnd[b]        = prod1_r[b] + PW'(32768);
      c2_nxt.rem[b] = '0;
      // divide: 2*|c|*65536 + |a|, premultiply: rounded product
      if (div1_r) begin
        c2_nxt.nq[b] = {cmag1_r[b], 17'b0} + QW'(ma1_r);
      end else begin
        c2_nxt.nq[b] = QW'(rnd[b][PW-1:16]);
      end
    end
  end

  assign cell_valid = v2_r;
  assign cell_data  = c2_r;

endmodule

[src/apu_div_cell.sv]
// one restoring division step for all colour bands, one quotient bit each
// premultiply items pass through unchanged
// depends on apu_pkg
module apu_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           valid_in,
  input  apu_pkg::cell_t data_in,
  output logic           valid_out,
  output apu_pkg::cell_t data_out
);
  import apu_pkg::*;

  logic          valid_r;
  cell_t         data_r, data_nxt;
  logic [RW:0]   rem2 [NCOL];
  logic [RW:0]   diff [NCOL];

  always_comb begin
    data_nxt = data_in;
    for (int b = 0; b < NCOL; b++) begin
      rem2[b] = {data_in.rem[b], data_in.nq[b][QW-1]};
      diff[b] = rem2[b] - (RW+1)'(data_in.d);
      if (data_in.divide) begin
        if (rem2[b] >= (RW+1)'(data_in.d)) begin
          data_nxt.rem[b] = diff[b][RW-1:0];
          data_nxt.nq[b]  = {data_in.nq[b][QW-2:0], 1'b1};
        end else begin
          data_nxt.rem[b] = rem2[b][RW-1:0];
          data_nxt.nq[b]  = {data_in.nq[b][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign valid_out = valid_r;
  assign data_out  = data_r;

endmodule

[src/alpha_premultiply_unit.sv]
// top level: apb floor register, front end, chain of divider cells, clip and output skid
// depends on apu_pkg, apu_front, apu_div_cell
//
//   channel  | ports                          | moves
//   input    | in_valid, in_stall, in_data    | one rgba pixel item plus func and last
//   result   | out_valid, out_stall, out_data | one converted pixel item
//   config   | psel..pready                   | alpha_floor at word 0
//
// one item per clock sustained while in_stall is low; the path runs through 3 front stages,
// 49 divider cells (one quotient bit per cell) and 1 output register
// reset clears all valid bits and sets alpha_floor to 1
// out_stall fills a one-entry skid; in_stall is the registered skid-full flag
module alpha_premultiply_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  apu_pkg::in_item_t       in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output apu_pkg::out_item_t      out_data,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [apu_pkg::AW-1:0]  paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import apu_pkg::*;

  logic [FLOOR_W-1:0] floor_r;
  logic               en;
  logic               vchain [QW+1];
  cell_t              cchain [QW+1];
  logic               skid_full_r, out_valid_r;
  out_item_t          out_r, skid_r, res;
  logic [CW-1:0]      rc [NCOL];
  logic [NCOL-1:0]    sat;
  logic               take;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ALPHA_FLOOR) ? {{(32-FLOOR_W){1'b0}}, floor_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= FLOOR_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_ALPHA_FLOOR)) begin
      floor_r <= pwdata[FLOOR_W-1:0];
    end
  end

  assign en       = !skid_full_r;
  assign in_stall = skid_full_r;

  apu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .floor_val  (floor_r),
    .cell_valid (vchain[0]),
    .cell_data  (cchain[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_cell
    apu_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .valid_in  (vchain[i]),
      .data_in   (cchain[i]),
      .valid_out (vchain[i+1]),
      .data_out  (cchain[i+1])
    );
  end

  // rounding is folded into the numerator, so the tail holds the final magnitude
  always_comb begin
    for (int b = 0; b < NCOL; b++) begin
      sat[b] = 1'b0;
      if (cchain[QW].zero) begin
        rc[b] = '0;
      end else if (!cchain[QW].neg[b]) begin
        if (cchain[QW].nq[b] > QW'(POS_MAX)) begin
          sat[b] = 1'b1;
          rc[b]  = POS_MAX;
        end else begin
          rc[b] = cchain[QW].nq[b][CW-1:0];
        end
      end else begin
        if (cchain[QW].nq[b] > QW'(NEG_MAX)) begin
          sat[b] = 1'b1;
          rc[b]  = NEG_MAX;
        end else begin
          rc[b] = ~cchain[QW].nq[b][CW-1:0] + CW'(1);
        end
      end
    end
    res.red_out   = rc[0];
    res.green_out = rc[1];
    res.blue_out  = rc[2];
    res.alpha_out = cchain[QW].alpha_out;
    res.saturated = |sat;
    res.last_out  = cchain[QW].last;
  end

  assign take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (take) begin
      if (skid_full_r) begin
        skid_full_r <= 1'b0;
      end else if (!vchain[QW]) begin
        out_valid_r <= 1'b0;
      end
    end else if (!out_valid_r) begin
      out_valid_r <= vchain[QW];
    end else if (en && vchain[QW]) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_full_r) begin
        out_r <= skid_r;
      end else begin
        out_r <= res;
      end
    end else if (!out_valid_r) begin
      out_r <= res;
    end else if (en) begin
      skid_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_skid_needs_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid holds an item while the output register is empty");

  a_skid_fills : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && !skid_full_r && vchain[QW]) |=> skid_full_r)
    else $error("item from the cell chain was dropped while output stalled");

  a_sat_extreme : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.saturated) |->
      (out_r.red_out == POS_MAX || out_r.red_out == NEG_MAX ||
       out_r.green_out == POS_MAX || out_r.green_out == NEG_MAX ||
       out_r.blue_out == POS_MAX || out_r.blue_out == NEG_MAX))
    else $error("saturated flag set with no clipped colour");

endmodule
